// ===== hw/rtl/pt_pkg.sv =====
// ----------------------------------------------------------------------------
// pt_pkg
// Shared widths, types and the voltage/temperature breakpoint table.
// ----------------------------------------------------------------------------
package pt_pkg;

  localparam int ADC_W      = 10;   // converter code width
  localparam int REF_W      = 13;   // reference voltage register width (mV)
  localparam int TEMP_OUT_W = 18;   // signed result width (centidegrees)
  localparam int VOLT_W     = 13;   // table voltage width (mV)
  localparam int TEMP_W     = 11;   // table temperature width (whole degrees)
  localparam int SCALED_W   = ADC_W + REF_W;

  localparam int STORED_POINTS = 49;
  localparam int IDX_W         = $clog2(STORED_POINTS);

  localparam int DEF_TABLE_POINTS   = 49;
  localparam int DEF_ADC_FULL_SCALE = 1023;

  localparam logic [REF_W-1:0] REF_RESET = REF_W'(5000);
  localparam logic signed [TEMP_OUT_W-1:0] ERR_CENTI = -TEMP_OUT_W'(100000);

  // rounding works on twice the centidegree scale
  localparam int CENTI_SCALE = 100;
  localparam int ROUND_SCALE = 200;

  localparam logic [VOLT_W-1:0] VOLT_MV [STORED_POINTS] = '{
    13'd0,    13'd1110, 13'd1150, 13'd1200, 13'd1240, 13'd1280, 13'd1320,
    13'd1360, 13'd1400, 13'd1440, 13'd1480, 13'd1520, 13'd1560, 13'd1610,
    13'd1650, 13'd1680, 13'd1720, 13'd1760, 13'd1800, 13'd1840, 13'd1880,
    13'd1920, 13'd1960, 13'd2000, 13'd2040, 13'd2070, 13'd2110, 13'd2150,
    13'd2180, 13'd2220, 13'd2260, 13'd2290, 13'd2330, 13'd2370, 13'd2410,
    13'd2440, 13'd2480, 13'd2510, 13'd2550, 13'd2580, 13'd2620, 13'd2660,
    13'd3000, 13'd3330, 13'd3630, 13'd3930, 13'd4210, 13'd4480, 13'd4730
  };

  localparam logic [TEMP_W-1:0] TEMP_DEG [STORED_POINTS] = '{
    11'd0,    11'd1,    11'd10,   11'd20,   11'd30,   11'd40,   11'd50,
    11'd60,   11'd70,   11'd80,   11'd90,   11'd100,  11'd110,  11'd120,
    11'd130,  11'd140,  11'd150,  11'd160,  11'd170,  11'd180,  11'd190,
    11'd200,  11'd210,  11'd220,  11'd230,  11'd240,  11'd250,  11'd260,
    11'd270,  11'd280,  11'd290,  11'd300,  11'd310,  11'd320,  11'd330,
    11'd340,  11'd350,  11'd360,  11'd370,  11'd380,  11'd390,  11'd400,
    11'd500,  11'd600,  11'd700,  11'd800,  11'd900,  11'd1000, 11'd1100
  };

  typedef struct packed {
    logic [VOLT_W-1:0] volt;
    logic [TEMP_W-1:0] temp;
  } entry_t;

endpackage

// ===== hw/rtl/pt_in_if.sv =====
// ----------------------------------------------------------------------------
// pt_in_if
// Sample channel: one converter code per word.
// ----------------------------------------------------------------------------
interface pt_in_if
  import pt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ADC_W-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

// ===== hw/rtl/pt_out_if.sv =====
// ----------------------------------------------------------------------------
// pt_out_if
// Result channel: temperature and range flag per word.
// ----------------------------------------------------------------------------
interface pt_out_if
  import pt_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic signed [TEMP_OUT_W-1:0] temp_centi;
  logic                         out_of_range;

  modport source (output valid, output temp_centi, output out_of_range, input ready);
  modport sink   (input valid, input temp_centi, input out_of_range, output ready);
endinterface

// ===== hw/rtl/pt_rom.sv =====
// ----------------------------------------------------------------------------
// pt_rom
// Breakpoint ROM, two synchronous (registered) read ports.
// ----------------------------------------------------------------------------
module pt_rom
  import pt_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] addr_a,
  input  logic [IDX_W-1:0] addr_b,
  output entry_t           rd_a,
  output entry_t           rd_b
);

  always_ff @(posedge clk) begin
    if (int'(addr_a) < STORED_POINTS) begin
      rd_a <= '{volt: VOLT_MV[addr_a], temp: TEMP_DEG[addr_a]};
    end else begin
      rd_a <= '0;
    end
    if (int'(addr_b) < STORED_POINTS) begin
      rd_b <= '{volt: VOLT_MV[addr_b], temp: TEMP_DEG[addr_b]};
    end else begin
      rd_b <= '0;
    end
  end

endmodule

// ===== hw/rtl/pt_div.sv =====
// ----------------------------------------------------------------------------
// pt_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module pt_div
  import pt_pkg::*;
#(
  parameter int DVD_W = 48,
  parameter int DVS_W = 30,
  parameter int QW    = 18
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [QW-1:0]    quotient
);

  localparam int CNT_W = $clog2(QW + 1);

  logic [DVD_W-1:0] rem;
  logic [DVD_W-1:0] dsh;     // divisor aligned to the current quotient bit
  logic [QW-1:0]    quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             dzero;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= dividend;
        dsh   <= DVD_W'(divisor) << (QW - 1);
        quo   <= '0;
        cnt   <= CNT_W'(QW);
        dzero <= (divisor == '0);
        busy  <= 1'b1;
      end else if (busy) begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          quo <= {quo[QW-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // zero-width interval reports no slope contribution
  assign quotient = dzero ? '0 : quo;

endmodule

// ===== hw/rtl/pt100_piecewise_linear_temp.sv =====
// ----------------------------------------------------------------------------
// pt100_piecewise_linear_temp
// PT100 amplifier code to temperature by piecewise-linear table lookup.
// ----------------------------------------------------------------------------
//
//  channel   dir  fields                       word
//  sample    in   adc_code[9:0]                one converter code
//  result    out  temp_centi[17:0] (signed),   temperature in 0.01 C,
//                 out_of_range                 -1000.00 when above table
//  cfg       in   cfg_we, cfg_data[12:0]       reference voltage in mV
//
//  One word at a time: an accepted sample is scaled, checked against the top
//  of the table, then walks the table, sets up and divides; out of range goes
//  straight from the check to done. The next word is taken after done.
//  rst is synchronous and clears control state; ref_millivolts resets to 5000.
//  A new sample is taken while the previous result still waits; the finished
//  word is held until the result register is free.
// ----------------------------------------------------------------------------
module pt100_piecewise_linear_temp
  import pt_pkg::*;
#(
  parameter int TABLE_POINTS   = DEF_TABLE_POINTS,
  parameter int ADC_FULL_SCALE = DEF_ADC_FULL_SCALE
) (
  input  logic             clk,
  input  logic             rst,
  pt_in_if.sink            sample,
  pt_out_if.source         result,
  input  logic             cfg_we,
  input  logic [REF_W-1:0] cfg_data
);

  // points actually used and the last usable index
  localparam int USED  = (TABLE_POINTS < STORED_POINTS) ? TABLE_POINTS : STORED_POINTS;
  localparam int LAST  = USED - 1;

  // voltage * full scale, numerator and divider widths
  localparam int FS_W   = $clog2(ADC_FULL_SCALE + 1);
  localparam int VFS_W  = VOLT_W + FS_W;
  localparam int CMP_W  = (SCALED_W > VFS_W) ? SCALED_W : VFS_W;
  localparam int DT_W   = TEMP_W + 8;            // 200 * temperature step
  localparam int DVD_W  = VFS_W + DT_W + 1;      // 200*dt*num + den
  localparam int DVS_W  = VFS_W + 1;             // 2*den
  localparam int QW     = TEMP_W + 7;            // quotient and 100*T base

  localparam logic [VFS_W-1:0] VLAST_FS =
    VFS_W'(VOLT_MV[LAST]) * VFS_W'(ADC_FULL_SCALE);

  typedef enum logic [3:0] {
    IDLE, SCALE, CHECK, SEARCH, SETUP1, SETUP2, SETUP3, START, DIVIDE, DONE
  } state_t;

  state_t state;

  logic [REF_W-1:0]    ref_millivolts;
  logic [ADC_W-1:0]    code;
  logic [SCALED_W-1:0] scaled;          // code * ref = voltage * FS
  logic [IDX_W-1:0]    k;               // ROM address of the upper point
  logic [IDX_W-1:0]    k_d;             // address of the data now on the ROM
  logic                pend;            // ROM data valid for k_d
  entry_t              lo;
  entry_t              hi;
  logic [VFS_W-1:0]    hi_vfs;
  logic [VFS_W-1:0]    den;
  logic [VFS_W-1:0]    num;
  logic [DT_W-1:0]     dt200;
  logic [QW-1:0]       tbase;
  logic [DVD_W-1:0]    dividend;

  logic                         out_valid;
  logic signed [TEMP_OUT_W-1:0] out_temp;
  logic                         out_oor;
  logic signed [TEMP_OUT_W-1:0] res_temp;
  logic                         res_oor;
  logic                         load_out;   // finished word moves to output

  entry_t              rd_a;
  entry_t              rd_b;
  logic [IDX_W-1:0]    addr_a;
  logic [VFS_W-1:0]    vfs_b;
  logic                stop;
  logic                div_start;
  logic                div_done;
  logic [QW-1:0]       quotient;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_millivolts <= REF_RESET;
    end else if (cfg_we) begin
      ref_millivolts <= cfg_data;
    end
  end

  // ROM: port b walks the upper point, port a the point below it
  assign addr_a = k - 1'b1;

  pt_rom u_rom (
    .clk    (clk),
    .addr_a (addr_a),
    .addr_b (k),
    .rd_a   (rd_a),
    .rd_b   (rd_b)
  );

  // first interval whose upper voltage covers the sample
  assign vfs_b = VFS_W'(rd_b.volt) * VFS_W'(ADC_FULL_SCALE);
  assign stop  = (CMP_W'(scaled) <= CMP_W'(vfs_b)) || (k_d >= IDX_W'(LAST));

  assign div_start = (state == START);

  // output register free now or emptied at this edge
  assign load_out = (state == DONE) && (!out_valid || result.ready);

  pt_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W),
    .QW    (QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  ({den, 1'b0}),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (sample.valid) begin
            code  <= sample.adc_code;
            state <= SCALE;
          end
        end
        SCALE: begin
          scaled <= SCALED_W'(code) * SCALED_W'(ref_millivolts);
          state  <= CHECK;
        end
        CHECK: begin
          if (CMP_W'(scaled) > CMP_W'(VLAST_FS)) begin
            res_temp <= ERR_CENTI;
            res_oor  <= 1'b1;
            state    <= DONE;
          end else begin
            k     <= IDX_W'(1);
            pend  <= 1'b0;
            state <= SEARCH;
          end
        end
        SEARCH: begin
          // one address issued per cycle; compare lags by the ROM latency
          if (k < IDX_W'(LAST)) begin
            k <= k + 1'b1;
          end
          k_d  <= k;
          pend <= 1'b1;
          if (pend && stop) begin
            lo     <= rd_a;
            hi     <= rd_b;
            hi_vfs <= vfs_b;
            state  <= SETUP1;
          end
        end
        SETUP1: begin
          den   <= VFS_W'(hi.volt - lo.volt) * VFS_W'(ADC_FULL_SCALE);
          dt200 <= DT_W'(hi.temp - lo.temp) * DT_W'(ROUND_SCALE);
          tbase <= QW'(lo.temp) * QW'(CENTI_SCALE);
          state <= SETUP2;
        end
        SETUP2: begin
          // offset from the lower point: scaled - V[lo]*FS
          num   <= VFS_W'(CMP_W'(scaled) - CMP_W'(hi_vfs - den));
          state <= SETUP3;
        end
        SETUP3: begin
          dividend <= DVD_W'(dt200) * DVD_W'(num) + DVD_W'(den);
          state    <= START;
        end
        START: begin
          state <= DIVIDE;
        end
        DIVIDE: begin
          if (div_done) begin
            res_temp <= TEMP_OUT_W'((QW + 1)'(tbase) + (QW + 1)'(quotient));
            res_oor  <= 1'b0;
            state    <= DONE;
          end
        end
        DONE: begin
          if (load_out) begin
            out_temp  <= res_temp;
            out_oor   <= res_oor;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign sample.ready        = (state == IDLE);
  assign result.valid        = out_valid;
  assign result.temp_centi   = out_temp;
  assign result.out_of_range = out_oor;

endmodule
